>>> hw/rtl/tcd_pkg.sv
// Shared types, character codes and the command alias table for the text
// command decoder. No dependencies; used by every module of the block.
package tcd_pkg;

   localparam int ALIAS_COUNT   = 23;
   localparam int ALIAS_MAX_LEN = 10;

   typedef logic [3:0]  command_type;
   typedef logic [22:0] alias_mask_type;

   localparam command_type CMD_UNKNOWN   = 4'd0;
   localparam command_type CMD_FORWARD   = 4'd1;
   localparam command_type CMD_REVERSE   = 4'd2;
   localparam command_type CMD_STOP      = 4'd3;
   localparam command_type CMD_LEFT      = 4'd4;
   localparam command_type CMD_RIGHT     = 4'd5;
   localparam command_type CMD_REV_LEFT  = 4'd6;
   localparam command_type CMD_REV_RIGHT = 4'd7;
   localparam command_type CMD_SPIN      = 4'd8;
   localparam command_type CMD_SPIN_CW   = 4'd9;
   localparam command_type CMD_SPIN_CCW  = 4'd10;
   localparam command_type CMD_RANDOM    = 4'd11;
   localparam command_type CMD_LIGHT     = 4'd12;
   localparam command_type CMD_TEMP      = 4'd13;
   localparam command_type CMD_DISTANCE  = 4'd14;
   localparam command_type CMD_SERVO     = 4'd15;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_QUERY = 8'h3F;

   localparam logic [15:0] MAG_LIMIT = 16'd32768;
   localparam logic [15:0] POS_MAX   = 16'd32767;

   // Alias text, right-justified: the first character sits in the highest used byte.
   localparam logic [ALIAS_MAX_LEN*8-1:0] ALIAS_TEXT [ALIAS_COUNT] = '{
      80'("frente"), 80'("fr"),
      80'("re"), 80'({8'h72, 8'hC3, 8'hA9}),
      80'("parar"), 80'("pa"),
      80'("esquerda"), 80'("fe"),
      80'("direita"), 80'("fd"),
      80'("reEsquerda"),
      80'("reDireita"), 80'("rd"),
      80'("girar"),
      80'("girarH"), 80'("gh"),
      80'("girarAH"), 80'("ga"),
      80'("aleatorio"),
      80'("sl"),
      80'("st"),
      80'("sd1"),
      80'("servo")
   };

   localparam logic [3:0] ALIAS_LEN [ALIAS_COUNT] = '{
      4'd6, 4'd2, 4'd2, 4'd3, 4'd5, 4'd2, 4'd8, 4'd2, 4'd7, 4'd2, 4'd10,
      4'd9, 4'd2, 4'd5, 4'd6, 4'd2, 4'd7, 4'd2, 4'd9, 4'd2, 4'd2, 4'd3, 4'd5
   };

   localparam command_type ALIAS_CODE [ALIAS_COUNT] = '{
      CMD_FORWARD, CMD_FORWARD, CMD_REVERSE, CMD_REVERSE, CMD_STOP, CMD_STOP,
      CMD_LEFT, CMD_LEFT, CMD_RIGHT, CMD_RIGHT, CMD_REV_LEFT,
      CMD_REV_RIGHT, CMD_REV_RIGHT, CMD_SPIN, CMD_SPIN_CW, CMD_SPIN_CW,
      CMD_SPIN_CCW, CMD_SPIN_CCW, CMD_RANDOM, CMD_LIGHT, CMD_TEMP,
      CMD_DISTANCE, CMD_SERVO
   };

   typedef enum logic [1:0] {
      PHASE_WORD,
      PHASE_PARAM,
      PHASE_DONE
   } parse_phase_type;

   typedef enum logic [1:0] {
      NUM_SPACE,
      NUM_DIGITS,
      NUM_STOP
   } num_phase_type;

   // Item held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } tcd_item_type;

   // Per-cycle control from the parser to the match and number units.
   typedef struct packed {
      logic fire;
      logic word_byte;
      logic param_byte;
      logic finish;
   } tcd_step_type;

   // Character at position pos of an alias; meaningful only for pos below its length.
   function automatic logic [7:0] alias_byte(input logic [4:0] idx, input logic [3:0] pos);
      logic [3:0] rev;
      rev = ALIAS_LEN[idx] - 4'd1 - pos;
      return ALIAS_TEXT[idx][{rev, 3'b000} +: 8];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

>>> hw/rtl/tcd_in_stage.sv
// Input register of the text command decoder: holds one byte item and
// stalls the sender while it cannot drain. Depends on tcd_pkg.
module tcd_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_message_byte,
   input  logic                req_last_byte,
   input  logic                go,
   output tcd_pkg::tcd_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       take;

   assign req_stall = valid_ff && !go;
   assign take      = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (go) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_message_byte;
         last_ff <= req_last_byte;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;
   assign item.last  = last_ff;

endmodule

>>> hw/rtl/tcd_match.sv
// Incremental alias matcher: narrows the candidate mask one byte at a time
// and resolves the command code on the final byte. Depends on tcd_pkg.
module tcd_match #(
   parameter int POS_BITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcd_pkg::tcd_step_type step,
   input  logic [7:0]            data,
   input  logic [POS_BITS-1:0]   pos,
   input  logic [POS_BITS-1:0]   final_len,
   output tcd_pkg::command_type  command_code
);

   tcd_pkg::alias_mask_type mask_ff, mask_in, keep, mask_upd;

   always_comb begin
      for (int i = 0; i < tcd_pkg::ALIAS_COUNT; i++) begin
         keep[i] = (pos < POS_BITS'(tcd_pkg::ALIAS_LEN[i]))
                   && (data == tcd_pkg::alias_byte(5'(i), pos[3:0]));
      end
   end

   assign mask_upd = step.word_byte ? (mask_ff & keep) : mask_ff;

   always_comb begin
      if (!step.fire) begin
         mask_in = mask_ff;
      end else if (step.finish) begin
         mask_in = '1;
      end else begin
         mask_in = mask_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '1;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // First alias in table order with an exact length match wins.
   always_comb begin
      command_code = tcd_pkg::CMD_UNKNOWN;
      for (int i = tcd_pkg::ALIAS_COUNT - 1; i >= 0; i--) begin
         if (mask_upd[i] && (final_len == POS_BITS'(tcd_pkg::ALIAS_LEN[i]))) begin
            command_code = tcd_pkg::ALIAS_CODE[i];
         end
      end
   end

endmodule

>>> hw/rtl/tcd_number.sv
// Parameter reader with atoi rules: whitespace, optional sign, decimal
// digits, saturated to 16-bit signed. Depends on tcd_pkg.
module tcd_number (
   input  logic                  clock,
   input  logic                  reset,
   input  tcd_pkg::tcd_step_type step,
   input  logic [7:0]            data,
   output logic signed [15:0]    parameter_value
);

   tcd_pkg::num_phase_type phase_ff, phase_in, phase_upd;
   logic        neg_ff, neg_in, neg_upd;
   logic [15:0] mag_ff, mag_in, mag_upd;
   logic [18:0] mag_sum;
   logic        is_space, is_sign, digit;

   assign digit    = tcd_pkg::is_digit(data);
   assign is_sign  = (data == tcd_pkg::CHAR_PLUS) || (data == tcd_pkg::CHAR_MINUS);
   assign is_space = (data == tcd_pkg::CHAR_SPACE)
                     || ((data >= tcd_pkg::CHAR_TAB) && (data <= tcd_pkg::CHAR_CR));

   // Next state
   always_comb begin
      phase_upd = phase_ff;
      if (step.param_byte) begin
         unique case (phase_ff)
            tcd_pkg::NUM_SPACE: begin
               if (is_space) begin
                  phase_upd = tcd_pkg::NUM_SPACE;
               end else if (is_sign || digit) begin
                  phase_upd = tcd_pkg::NUM_DIGITS;
               end else begin
                  phase_upd = tcd_pkg::NUM_STOP;
               end
            end
            tcd_pkg::NUM_DIGITS: begin
               phase_upd = digit ? tcd_pkg::NUM_DIGITS : tcd_pkg::NUM_STOP;
            end
            tcd_pkg::NUM_STOP: begin
               phase_upd = tcd_pkg::NUM_STOP;
            end
            default: begin
               phase_upd = tcd_pkg::NUM_STOP;
            end
         endcase
      end
      if (!step.fire) begin
         phase_in = phase_ff;
      end else if (step.finish) begin
         phase_in = tcd_pkg::NUM_SPACE;
      end else begin
         phase_in = phase_upd;
      end
   end

   // Accumulator and sign
   assign mag_sum = ({3'b000, mag_ff} << 3) + ({3'b000, mag_ff} << 1)
                    + {11'd0, data - tcd_pkg::CHAR_ZERO};

   always_comb begin
      mag_upd = mag_ff;
      neg_upd = neg_ff;
      if (step.param_byte && (phase_ff == tcd_pkg::NUM_SPACE) && is_sign) begin
         neg_upd = (data == tcd_pkg::CHAR_MINUS);
      end
      if (step.param_byte && digit && (phase_ff != tcd_pkg::NUM_STOP)) begin
         mag_upd = (mag_sum > {3'b000, tcd_pkg::MAG_LIMIT}) ? tcd_pkg::MAG_LIMIT
                                                              : mag_sum[15:0];
      end
      if (!step.fire) begin
         mag_in = mag_ff;
         neg_in = neg_ff;
      end else if (step.finish) begin
         mag_in = '0;
         neg_in = 1'b0;
      end else begin
         mag_in = mag_upd;
         neg_in = neg_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tcd_pkg::NUM_SPACE;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
      end
   end

   always_comb begin
      if (neg_upd) begin
         parameter_value = signed'(16'(~mag_upd + 16'd1));
      end else if (mag_upd > tcd_pkg::POS_MAX) begin
         parameter_value = signed'(tcd_pkg::POS_MAX);
      end else begin
         parameter_value = signed'(mag_upd);
      end
   end

endmodule

>>> hw/rtl/text_command_decoder.sv
// Text command decoder top level: byte parser, result register and the assertions
// on parser and stall state. Depends on tcd_pkg, tcd_in_stage, tcd_match, tcd_number.
//
// Usage:
//   req_ channel carries one message byte per item; req_last_byte marks the
//   end of a message. Only the final byte produces a rsp_ item: command code
//   (0 when no alias matches), signed parameter after '?', and whether a
//   '?' followed a non-empty command word. Bytes beyond MESSAGE_BYTES are
//   ignored but still end the message when flagged last.
// Timing:
//   A byte passes an input register and then the combinational matching
//   logic into the result register, which offers the result of a last byte
//   on rsp_. One byte per cycle is taken unless a last byte waits behind a
//   stalled result; the matcher and number reader each update once per byte.
// Stall and reset:
//   A waiting result does not block bytes that are not last; only a last
//   byte behind a stalled result stops the input. Reset clears the parser
//   to the start of a message and drops any pending item.
module text_command_decoder #(
   parameter int MESSAGE_BYTES = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_message_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_command_code,
   output logic signed [15:0] rsp_parameter_value,
   output logic               rsp_has_parameter
);

   localparam int POS_BITS = $clog2(MESSAGE_BYTES + 1);

   tcd_pkg::tcd_item_type    item;
   tcd_pkg::tcd_step_type    step;
   tcd_pkg::parse_phase_type phase_ff, phase_in, phase_upd;
   logic [POS_BITS-1:0] pos_ff, pos_in, pos_upd;
   logic [POS_BITS-1:0] word_len_ff, word_len_in, word_len_upd, final_len;
   logic                sep_ff, sep_in, sep_upd;
   logic                go, in_window, is_query, is_nul, word_end;
   tcd_pkg::command_type    code;
   logic signed [15:0]      value;

   logic                    rsp_valid_ff, rsp_valid_in;
   tcd_pkg::command_type    rsp_code_ff;
   logic signed [15:0]      rsp_value_ff;
   logic                    rsp_has_ff;

   assign go = item.valid && (!item.last || !rsp_valid_ff || !rsp_stall);

   tcd_in_stage u_in_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_byte (req_message_byte),
      .req_last_byte    (req_last_byte),
      .go               (go),
      .item             (item)
   );

   assign in_window = pos_ff < POS_BITS'(MESSAGE_BYTES);
   assign is_query  = item.data == tcd_pkg::CHAR_QUERY;
   assign is_nul    = item.data == tcd_pkg::CHAR_NUL;
   assign word_end  = in_window && (phase_ff == tcd_pkg::PHASE_WORD) && (is_query || is_nul);

   // Next state
   always_comb begin
      phase_upd = phase_ff;
      if (in_window) begin
         unique case (phase_ff)
            tcd_pkg::PHASE_WORD: begin
               if (is_query) begin
                  phase_upd = (pos_ff != '0) ? tcd_pkg::PHASE_PARAM : tcd_pkg::PHASE_DONE;
               end else if (is_nul) begin
                  phase_upd = tcd_pkg::PHASE_DONE;
               end
            end
            tcd_pkg::PHASE_PARAM: begin
               if (is_nul) begin
                  phase_upd = tcd_pkg::PHASE_DONE;
               end
            end
            tcd_pkg::PHASE_DONE: begin
               phase_upd = tcd_pkg::PHASE_DONE;
            end
            default: begin
               phase_upd = tcd_pkg::PHASE_DONE;
            end
         endcase
      end
      if (!go) begin
         phase_in = phase_ff;
      end else if (item.last) begin
         phase_in = tcd_pkg::PHASE_WORD;
      end else begin
         phase_in = phase_upd;
      end
   end

   // Outputs to the match and number units
   always_comb begin
      step.fire       = go;
      step.finish     = go && item.last;
      step.word_byte  = go && in_window && (phase_ff == tcd_pkg::PHASE_WORD)
                        && !is_query && !is_nul;
      step.param_byte = go && in_window && (phase_ff == tcd_pkg::PHASE_PARAM) && !is_nul;
   end

   always_comb begin
      pos_upd      = in_window ? (pos_ff + 1'b1) : pos_ff;
      word_len_upd = word_end ? pos_ff : word_len_ff;
      sep_upd      = sep_ff || (word_end && is_query && (pos_ff != '0));
      // An open word ends at the current position.
      final_len    = (phase_upd == tcd_pkg::PHASE_WORD) ? pos_upd : word_len_upd;
      if (!go) begin
         pos_in      = pos_ff;
         word_len_in = word_len_ff;
         sep_in      = sep_ff;
      end else if (item.last) begin
         pos_in      = '0;
         word_len_in = '0;
         sep_in      = 1'b0;
      end else begin
         pos_in      = pos_upd;
         word_len_in = word_len_upd;
         sep_in      = sep_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= tcd_pkg::PHASE_WORD;
         pos_ff      <= '0;
         word_len_ff <= '0;
         sep_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         word_len_ff <= word_len_in;
         sep_ff      <= sep_in;
      end
   end

   tcd_match #(
      .POS_BITS (POS_BITS)
   ) u_match (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data         (item.data),
      .pos          (pos_ff),
      .final_len    (final_len),
      .command_code (code)
   );

   tcd_number u_number (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .data            (item.data),
      .parameter_value (value)
   );

   // Result register: load on the last byte, hold while stalled.
   assign rsp_valid_in = step.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.finish) begin
         rsp_code_ff  <= code;
         rsp_value_ff <= value;
         rsp_has_ff   <= sep_upd;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_command_code    = rsp_code_ff;
   assign rsp_parameter_value = rsp_value_ff;
   assign rsp_has_parameter   = rsp_has_ff;

`ifndef SYNTHESIS
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step.finish |=> (pos_ff == '0 && !sep_ff && phase_ff == tcd_pkg::PHASE_WORD))
      else $error("parser did not return to message start after last byte");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_BITS'(MESSAGE_BYTES))
      else $error("byte position past message window");

   a_sep_word: assert property (@(posedge clock) disable iff (reset)
      sep_ff |-> (word_len_ff != '0))
      else $error("separator seen with empty command word");

   a_param_sep: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tcd_pkg::PHASE_PARAM) |-> sep_ff)
      else $error("parameter phase without separator");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item.valid && item.last && rsp_valid_ff))
      else $error("input stalled without a blocked last byte");
`endif

endmodule

>>> sim/text_command_decoder_tb.sv
// Self-checking testbench for text_command_decoder: directed messages, then random
// messages with random idling on both channels. Depends on tcd_pkg and the RTL only.
`timescale 1ns / 100ps

module text_command_decoder_tb;

   localparam int MSG_WINDOW   = 15;
   localparam int ALIASES      = 23;
   localparam int RANDOM_BYTES = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int DIR_ROWS     = 29;
   localparam byte NUL_STAND_IN = "~";

   typedef struct packed {
      tcd_pkg::command_type code;
      logic signed [15:0]   value;
      logic                 has;
   } decode_type;

   typedef struct packed {
      logic       typed;
      decode_type want;
   } pinned_type;

   localparam pinned_type UNPINNED = '0;

   localparam tcd_pkg::command_type ALIAS_CMD [ALIASES] = '{
      tcd_pkg::CMD_FORWARD, tcd_pkg::CMD_FORWARD, tcd_pkg::CMD_REVERSE,
      tcd_pkg::CMD_REVERSE, tcd_pkg::CMD_STOP, tcd_pkg::CMD_STOP,
      tcd_pkg::CMD_LEFT, tcd_pkg::CMD_LEFT, tcd_pkg::CMD_RIGHT, tcd_pkg::CMD_RIGHT,
      tcd_pkg::CMD_REV_LEFT, tcd_pkg::CMD_REV_RIGHT, tcd_pkg::CMD_REV_RIGHT,
      tcd_pkg::CMD_SPIN, tcd_pkg::CMD_SPIN_CW, tcd_pkg::CMD_SPIN_CW,
      tcd_pkg::CMD_SPIN_CCW, tcd_pkg::CMD_SPIN_CCW, tcd_pkg::CMD_RANDOM,
      tcd_pkg::CMD_LIGHT, tcd_pkg::CMD_TEMP, tcd_pkg::CMD_DISTANCE, tcd_pkg::CMD_SERVO
   };

   // '~' stands for a NUL byte in these rows.
   string dir_text [DIR_ROWS] = '{
      "fr", "frente?100", "re", "r\303\251?-5", "parar?+7", "pa", "esquerda?\t 8",
      "fe", "direita?  42x", "fd?0", "reEsquerda?-32768", "reDireita?99999",
      "rd?-99999", "girar", "girarH?1~9", "gh?--3", "girarAH? + 4", "ga?12ab",
      "aleatorio?abc", "sl~?5", "st?32768", "sd1?-32768", "servo?180", "?12", "~",
      "abcdefghijklmnop?3", "xyz?-1", "r", "\377\200"
   };

   pinned_type dir_pin [DIR_ROWS] = '{
      '{1'b1, '{tcd_pkg::CMD_FORWARD, 16'sd0, 1'b0}},
      '{1'b1, '{tcd_pkg::CMD_FORWARD, 16'sd100, 1'b1}},
      '{1'b1, '{tcd_pkg::CMD_REVERSE, 16'sd0, 1'b0}},
      '{1'b1, '{tcd_pkg::CMD_REVERSE, -16'sd5, 1'b1}},
      UNPINNED, UNPINNED, UNPINNED, UNPINNED, UNPINNED, UNPINNED,
      '{1'b1, '{tcd_pkg::CMD_REV_LEFT, -16'sd327, 1'b1}},
      '{1'b1, '{tcd_pkg::CMD_REV_RIGHT, 16'sd32767, 1'b1}},
      '{1'b1, '{tcd_pkg::CMD_REV_RIGHT, -16'sd32768, 1'b1}},
      UNPINNED, UNPINNED, UNPINNED, UNPINNED, UNPINNED, UNPINNED,
      '{1'b1, '{tcd_pkg::CMD_LIGHT, 16'sd0, 1'b0}},
      '{1'b1, '{tcd_pkg::CMD_TEMP, 16'sd32767, 1'b1}},
      '{1'b1, '{tcd_pkg::CMD_DISTANCE, -16'sd32768, 1'b1}},
      UNPINNED,
      '{1'b1, '{tcd_pkg::CMD_UNKNOWN, 16'sd0, 1'b0}},
      '{1'b1, '{tcd_pkg::CMD_UNKNOWN, 16'sd0, 1'b0}},
      '{1'b1, '{tcd_pkg::CMD_UNKNOWN, 16'sd0, 1'b0}},
      '{1'b1, '{tcd_pkg::CMD_UNKNOWN, -16'sd1, 1'b1}},
      '{1'b1, '{tcd_pkg::CMD_UNKNOWN, 16'sd0, 1'b0}},
      '{1'b1, '{tcd_pkg::CMD_UNKNOWN, 16'sd0, 1'b0}}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_message_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_command_code;
   logic signed [15:0] rsp_parameter_value;
   logic               rsp_has_parameter;

   // Decoder state mirrored by the predictor.
   int unsigned              win_pos;
   tcd_pkg::parse_phase_type word_phase;
   tcd_pkg::alias_mask_type  live_aliases;
   tcd_pkg::num_phase_type   digit_phase;
   logic                     minus;
   int unsigned              magnitude;
   logic                     got_query;
   int unsigned              word_len;

   decode_type pending_decodes [$];
   pinned_type pinned_decodes [$];
   logic [7:0] outgoing [$];

   logic       calm = 1'b0;
   int         stall_left = 0;
   int         mismatch_count = 0;
   int         decodes_checked = 0;
   int         bytes_sent = 0;
   int         messages_sent = 0;
   logic       produced;
   decode_type predicted, observed, oldest;
   pinned_type pin;

   text_command_decoder #(.MESSAGE_BYTES(MSG_WINDOW)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_message_byte(req_message_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_command_code(rsp_command_code),
      .rsp_parameter_value(rsp_parameter_value),
      .rsp_has_parameter(rsp_has_parameter)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   function automatic string alias_text(input int k);
      case (k)
         0: return "frente";
         1: return "fr";
         2: return "re";
         3: return "r\303\251";
         4: return "parar";
         5: return "pa";
         6: return "esquerda";
         7: return "fe";
         8: return "direita";
         9: return "fd";
         10: return "reEsquerda";
         11: return "reDireita";
         12: return "rd";
         13: return "girar";
         14: return "girarH";
         15: return "gh";
         16: return "girarAH";
         17: return "ga";
         18: return "aleatorio";
         19: return "sl";
         20: return "st";
         21: return "sd1";
         default: return "servo";
      endcase
   endfunction

   function automatic int idle_cycles();
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   task automatic clear_decoder();
      win_pos = 0;
      word_phase = tcd_pkg::PHASE_WORD;
      live_aliases = '1;
      digit_phase = tcd_pkg::NUM_SPACE;
      minus = 1'b0;
      magnitude = 0;
      got_query = 1'b0;
      word_len = 0;
   endtask

   // Advance the decoder by one byte; a last byte yields the decode and restarts.
   task automatic decode_byte(input logic [7:0] c, input logic last,
                              output logic done, output decode_type res);
      string s;
      logic  digit;
      logic  sign_taken;
      digit = (c >= tcd_pkg::CHAR_ZERO) && (c <= tcd_pkg::CHAR_NINE);
      sign_taken = 1'b0;
      res = '0;
      if (win_pos < MSG_WINDOW) begin
         case (word_phase)
            tcd_pkg::PHASE_WORD: begin
               if (c == tcd_pkg::CHAR_QUERY) begin
                  word_len = win_pos;
                  if (win_pos > 0) begin
                     got_query = 1'b1;
                     word_phase = tcd_pkg::PHASE_PARAM;
                  end else begin
                     word_phase = tcd_pkg::PHASE_DONE;
                  end
               end else if (c == tcd_pkg::CHAR_NUL) begin
                  word_len = win_pos;
                  word_phase = tcd_pkg::PHASE_DONE;
               end else begin
                  for (int k = 0; k < ALIASES; k++) begin
                     s = alias_text(k);
                     if (!(win_pos < s.len() && s[win_pos] == c))
                        live_aliases[k] = 1'b0;
                  end
               end
            end
            tcd_pkg::PHASE_PARAM: begin
               if (c == tcd_pkg::CHAR_NUL) begin
                  word_phase = tcd_pkg::PHASE_DONE;
               end else begin
                  if (digit_phase == tcd_pkg::NUM_SPACE) begin
                     if (c == tcd_pkg::CHAR_SPACE
                         || (c >= tcd_pkg::CHAR_TAB && c <= tcd_pkg::CHAR_CR)) begin
                        // skip leading whitespace
                     end else if (c == tcd_pkg::CHAR_PLUS || c == tcd_pkg::CHAR_MINUS) begin
                        minus = (c == tcd_pkg::CHAR_MINUS);
                        digit_phase = tcd_pkg::NUM_DIGITS;
                        sign_taken = 1'b1;
                     end else begin
                        digit_phase = digit ? tcd_pkg::NUM_DIGITS : tcd_pkg::NUM_STOP;
                     end
                  end
                  if (!sign_taken && digit_phase == tcd_pkg::NUM_DIGITS) begin
                     if (digit) begin
                        magnitude = magnitude * 10 + (c - tcd_pkg::CHAR_ZERO);
                        if (magnitude > tcd_pkg::MAG_LIMIT)
                           magnitude = tcd_pkg::MAG_LIMIT;
                     end else begin
                        digit_phase = tcd_pkg::NUM_STOP;
                     end
                  end
               end
            end
            default: ;
         endcase
         win_pos++;
      end
      done = last;
      if (last) begin
         if (word_phase == tcd_pkg::PHASE_WORD)
            word_len = win_pos;
         res.code = tcd_pkg::CMD_UNKNOWN;
         // Walk backward so the first alias in table order wins.
         for (int k = ALIASES - 1; k >= 0; k--) begin
            s = alias_text(k);
            if (live_aliases[k] && s.len() == word_len)
               res.code = ALIAS_CMD[k];
         end
         if (!got_query)
            res.value = '0;
         else if (minus)
            res.value = 16'(-int'(magnitude));
         else
            res.value = (magnitude > tcd_pkg::POS_MAX) ? tcd_pkg::POS_MAX : 16'(magnitude);
         res.has = got_query;
         clear_decoder();
      end
   endtask

   task automatic note_mismatch(input string msg);
      if (mismatch_count < 10)
         $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_decode(input string src, input decode_type want,
                                 input decode_type got);
      if (want.code !== got.code || want.value !== got.value || want.has !== got.has)
         note_mismatch($sformatf("%s: expected code %0d value %0d has %0b, got %0d %0d %0b",
                                 src, want.code, want.value, want.has,
                                 got.code, got.value, got.has));
   endtask

   // Check results first, then predict from the byte taken at this edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            observed = '{rsp_command_code, rsp_parameter_value, rsp_has_parameter};
            if (pending_decodes.size() == 0) begin
               note_mismatch($sformatf("unexpected result code %0d value %0d has %0b",
                                       observed.code, observed.value, observed.has));
            end else begin
               oldest = pending_decodes.pop_front();
               compare_decode("predicted", oldest, observed);
               if (pinned_decodes.size() != 0) begin
                  pin = pinned_decodes.pop_front();
                  if (pin.typed)
                     compare_decode("directed", pin.want, observed);
               end
            end
            decodes_checked++;
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_message_byte, req_last_byte, produced, predicted);
            if (produced)
               pending_decodes.push_back(predicted);
         end
      end
   end

   // Stall the result side for a random count after each accepted item.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            stall_left = idle_cycles();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_message();
      int gap;
      for (int i = 0; i < outgoing.size(); i++) begin
         gap = idle_cycles();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_message_byte <= outgoing[i];
         req_last_byte <= (i == outgoing.size() - 1);
         do @(posedge clock); while (req_stall !== 1'b0);
         bytes_sent++;
      end
      messages_sent++;
   endtask

   initial begin
      string s;
      int    directed_bytes;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         outgoing.delete();
         s = dir_text[r];
         for (int i = 0; i < s.len(); i++)
            outgoing.push_back(s[i] == NUL_STAND_IN ? tcd_pkg::CHAR_NUL : s[i]);
         pinned_decodes.push_back(dir_pin[r]);
         send_message();
      end
      directed_bytes = bytes_sent;

      while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
         if (messages_sent % 12 == 0)
            calm = ($urandom_range(0, 3) == 0);
         outgoing.delete();
         if ($urandom_range(0, 9) < 7) begin
            // Well-formed alias, sometimes damaged, usually with a parameter.
            s = alias_text($urandom_range(0, ALIASES - 1));
            for (int i = 0; i < s.len(); i++)
               outgoing.push_back(s[i]);
            if ($urandom_range(0, 7) == 0)
               outgoing[$urandom_range(0, outgoing.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0 && outgoing.size() > 1)
               void'(outgoing.pop_back());
            if ($urandom_range(0, 3) != 0) begin
               outgoing.push_back(tcd_pkg::CHAR_QUERY);
               repeat ($urandom_range(0, 2))
                  outgoing.push_back($urandom_range(0, 1) ? tcd_pkg::CHAR_SPACE
                                                          : 8'($urandom_range(9, 13)));
               case ($urandom_range(0, 3))
                  0: outgoing.push_back(tcd_pkg::CHAR_MINUS);
                  1: outgoing.push_back(tcd_pkg::CHAR_PLUS);
                  default: ;
               endcase
               repeat ($urandom_range(0, 6))
                  outgoing.push_back(tcd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
               if ($urandom_range(0, 3) == 0)
                  outgoing.push_back(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 2) == 0) begin
               outgoing.push_back(tcd_pkg::CHAR_NUL);
               repeat ($urandom_range(0, 3))
                  outgoing.push_back(8'($urandom_range(0, 255)));
            end
         end else begin
            // Noise, sometimes long enough to run past the window.
            repeat ($urandom_range(1, 20))
               outgoing.push_back($urandom_range(0, 5) == 0 ? tcd_pkg::CHAR_QUERY
                                                            : 8'($urandom_range(0, 255)));
         end
         pinned_decodes.push_back(UNPINNED);
         send_message();
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (pending_decodes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pinned_decodes.size() != 0)
         note_mismatch($sformatf("%0d messages produced no result", pinned_decodes.size()));

      $display("Sent %0d bytes in %0d messages (%0d directed rows), %0d results checked,",
               bytes_sent, messages_sent, DIR_ROWS, decodes_checked);
      $display("%0d mismatches found", mismatch_count);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
